// File: rtl/core/segrect_pkg.sv
// Package for the segment/rectangle hit test: defaults, edge indexes and flag types.
package segrect_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// rectangle edges, in the order the flags carry them
	localparam int EDGE_TOP    = 0;
	localparam int EDGE_LEFT   = 1;
	localparam int EDGE_BOTTOM = 2;
	localparam int EDGE_RIGHT  = 3;
	localparam int NUM_EDGES   = 4;

	// comparison results that travel down the pipeline next to the products
	typedef struct packed {
		logic                 in0;   // first endpoint inside or on the rectangle
		logic                 in1;   // second endpoint inside or on the rectangle
		logic [NUM_EDGES-1:0] span;  // segment's box reaches the edge's line and overlaps its extent, per edge
	} flags_t;

	// sign of an orientation cross product
	typedef struct packed {
		logic pos;
		logic neg;
	} sgn_t;

endpackage

// File: rtl/core/segment_rectangle_hit_test.sv
// Segment/rectangle hit test: four-stage pipeline, one transaction per cycle while the output is not stalled.
//
// Takes one query per clock cycle while no result is held; stage 4 registers
// its hit flag. Stage 1 orders the rectangle corners and forms the coordinate
// differences, stage 2 runs the four (COORD_WIDTH+1)-bit signed multipliers
// and the bound compares, stage 3 forms the corner cross products, stage 4
// combines the edge tests. The whole pipeline advances together, so a held
// result (res_valid high, res_ready low) holds every stage and drops
// item_ready in the same cycle; nothing is lost or repeated.
module segment_rectangle_hit_test #(
	parameter int COORD_WIDTH = segrect_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] seg_x0,
	input  logic signed [COORD_WIDTH-1:0] seg_y0,
	input  logic signed [COORD_WIDTH-1:0] seg_x1,
	input  logic signed [COORD_WIDTH-1:0] seg_y1,
	input  logic signed [COORD_WIDTH-1:0] rect_xa,
	input  logic signed [COORD_WIDTH-1:0] rect_ya,
	input  logic signed [COORD_WIDTH-1:0] rect_xb,
	input  logic signed [COORD_WIDTH-1:0] rect_yb,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          hit
);
	import segrect_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int D = W + 1;      // coordinate difference
	localparam int P = 2 * D;      // product
	localparam int C = P + 1;      // difference of products

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv        = !v_s4 || res_ready;
	assign item_ready = adv;
	assign res_valid  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: order corners, differences
	logic signed [W-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
	logic signed [D-1:0] px_e, py_e, qx_e, qy_e, xa_e, xb_e, ya_e, yb_e;
	logic                xa_lt, ya_lt;

	assign xa_lt = rect_xa < rect_xb;
	assign ya_lt = rect_ya < rect_yb;
	assign xlo_c = xa_lt ? rect_xa : rect_xb;
	assign xhi_c = xa_lt ? rect_xb : rect_xa;
	assign ylo_c = ya_lt ? rect_ya : rect_yb;
	assign yhi_c = ya_lt ? rect_yb : rect_ya;

	assign px_e = {seg_x0[W-1], seg_x0};
	assign py_e = {seg_y0[W-1], seg_y0};
	assign qx_e = {seg_x1[W-1], seg_x1};
	assign qy_e = {seg_y1[W-1], seg_y1};
	assign xa_e = {rect_xa[W-1], rect_xa};
	assign xb_e = {rect_xb[W-1], rect_xb};
	assign ya_e = {rect_ya[W-1], rect_ya};
	assign yb_e = {rect_yb[W-1], rect_yb};

	logic signed [W-1:0] px_s1, py_s1, qx_s1, qy_s1;
	logic signed [W-1:0] xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic signed [D-1:0] dx_s1, dy_s1, eyh_s1, eyl_s1, exl_s1, exh_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= seg_x0;
			py_s1  <= seg_y0;
			qx_s1  <= seg_x1;
			qy_s1  <= seg_y1;
			xlo_s1 <= xlo_c;
			xhi_s1 <= xhi_c;
			ylo_s1 <= ylo_c;
			yhi_s1 <= yhi_c;
			dx_s1  <= qx_e - px_e;
			dy_s1  <= qy_e - py_e;
			// both corner differences are formed and the ordered one picked
			eyh_s1 <= ya_lt ? (yb_e - py_e) : (ya_e - py_e);
			eyl_s1 <= ya_lt ? (ya_e - py_e) : (yb_e - py_e);
			exl_s1 <= xa_lt ? (xa_e - px_e) : (xb_e - px_e);
			exh_s1 <= xa_lt ? (xb_e - px_e) : (xa_e - px_e);
		end
	end

	// ---------------- stage 2: products and bound compares
	logic   x_over, y_over, xlo_in, xhi_in, ylo_in, yhi_in;
	flags_t flags_c;

	assign x_over = (px_s1 >= xlo_s1 || qx_s1 >= xlo_s1) && (px_s1 <= xhi_s1 || qx_s1 <= xhi_s1);
	assign y_over = (py_s1 >= ylo_s1 || qy_s1 >= ylo_s1) && (py_s1 <= yhi_s1 || qy_s1 <= yhi_s1);
	assign xlo_in = (px_s1 <= xlo_s1 || qx_s1 <= xlo_s1) && (px_s1 >= xlo_s1 || qx_s1 >= xlo_s1);
	assign xhi_in = (px_s1 <= xhi_s1 || qx_s1 <= xhi_s1) && (px_s1 >= xhi_s1 || qx_s1 >= xhi_s1);
	assign ylo_in = (py_s1 <= ylo_s1 || qy_s1 <= ylo_s1) && (py_s1 >= ylo_s1 || qy_s1 >= ylo_s1);
	assign yhi_in = (py_s1 <= yhi_s1 || qy_s1 <= yhi_s1) && (py_s1 >= yhi_s1 || qy_s1 >= yhi_s1);

	always_comb begin
		flags_c.in0 = px_s1 >= xlo_s1 && px_s1 <= xhi_s1 && py_s1 >= ylo_s1 && py_s1 <= yhi_s1;
		flags_c.in1 = qx_s1 >= xlo_s1 && qx_s1 <= xhi_s1 && qy_s1 >= ylo_s1 && qy_s1 <= yhi_s1;
		// the edge's own side test is implied by its interval check
		flags_c.span[EDGE_TOP]    = x_over && yhi_in;
		flags_c.span[EDGE_LEFT]   = xlo_in && y_over;
		flags_c.span[EDGE_BOTTOM] = x_over && ylo_in;
		flags_c.span[EDGE_RIGHT]  = xhi_in && y_over;
	end

	logic signed [P-1:0] pyh_s2, pyl_s2, pxl_s2, pxh_s2;
	flags_t              flags_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pyh_s2   <= dx_s1 * eyh_s1;
			pyl_s2   <= dx_s1 * eyl_s1;
			pxl_s2   <= dy_s1 * exl_s1;
			pxh_s2   <= dy_s1 * exh_s1;
			flags_s2 <= flags_c;
		end
	end

	// ---------------- stage 3: orientation of each corner w.r.t. the segment
	logic signed [C-1:0] cr_tl, cr_tr, cr_bl, cr_br;

	assign cr_tl = C'(pyh_s2) - C'(pxl_s2);
	assign cr_tr = C'(pyh_s2) - C'(pxh_s2);
	assign cr_bl = C'(pyl_s2) - C'(pxl_s2);
	assign cr_br = C'(pyl_s2) - C'(pxh_s2);

	sgn_t   tl_s3, tr_s3, bl_s3, br_s3;
	flags_t flags_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			tl_s3    <= '{pos: !cr_tl[C-1] && cr_tl != '0, neg: cr_tl[C-1]};
			tr_s3    <= '{pos: !cr_tr[C-1] && cr_tr != '0, neg: cr_tr[C-1]};
			bl_s3    <= '{pos: !cr_bl[C-1] && cr_bl != '0, neg: cr_bl[C-1]};
			br_s3    <= '{pos: !cr_br[C-1] && cr_br != '0, neg: cr_br[C-1]};
			flags_s3 <= flags_s2;
		end
	end

	// ---------------- stage 4: combine
	logic [NUM_EDGES-1:0] same_side;
	logic                 hit_c;

	assign same_side[EDGE_TOP]    = (tl_s3.pos && tr_s3.pos) || (tl_s3.neg && tr_s3.neg);
	assign same_side[EDGE_LEFT]   = (tl_s3.pos && bl_s3.pos) || (tl_s3.neg && bl_s3.neg);
	assign same_side[EDGE_BOTTOM] = (br_s3.pos && bl_s3.pos) || (br_s3.neg && bl_s3.neg);
	assign same_side[EDGE_RIGHT]  = (br_s3.pos && tr_s3.pos) || (br_s3.neg && tr_s3.neg);

	assign hit_c = flags_s3.in0 || flags_s3.in1 || |(flags_s3.span & ~same_side);

	logic hit_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s4 <= hit_c;
		end
	end

	assign hit = hit_s4;

endmodule

// File: rtl/core/segrect_checker.sv
// Port-level checker for the segment/rectangle hit test, with its bind.
module segrect_checker #(
	parameter int COORD_WIDTH = segrect_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic signed [COORD_WIDTH-1:0] seg_x0,
	input logic signed [COORD_WIDTH-1:0] seg_y0,
	input logic signed [COORD_WIDTH-1:0] seg_x1,
	input logic signed [COORD_WIDTH-1:0] rect_xa,
	input logic signed [COORD_WIDTH-1:0] rect_ya,
	input logic signed [COORD_WIDTH-1:0] rect_xb,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          hit
);

	logic acc;
	logic on_corner;
	logic left_of;

	assign acc       = item_valid && item_ready;
	assign on_corner = seg_x0 == rect_xa && seg_y0 == rect_ya;
	assign left_of   = seg_x0 < rect_xa && seg_x1 < rect_xa && seg_x0 < rect_xb && seg_x1 < rect_xb;

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(hit))
		else $error("result changed while stalled");

	// a stalled output stops new transactions
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !item_ready)
		else $error("input accepted while output stalled");

	// endpoint on a corner must hit, when the output does not stall in between
	a_corner_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && on_corner && res_ready) ##1 res_ready ##1 res_ready ##1 res_ready
		|=> res_valid && hit)
		else $error("endpoint on corner not reported as hit");

	// segment wholly left of the rectangle must miss
	a_left_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && left_of && res_ready) ##1 res_ready ##1 res_ready ##1 res_ready
		|=> res_valid && !hit)
		else $error("disjoint segment reported as hit");

endmodule

bind segment_rectangle_hit_test segrect_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);
